[sv/tcw_pkg.sv]
package tcw_pkg;

   localparam int KIND_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int COL_W       = 7;
   localparam int ROW_W       = 5;
   localparam int POS_W       = 11;
   localparam int CELL_W      = 16;
   localparam int COLOR_W     = 4;
   localparam int CSR_INDEX_W = 1;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;
   localparam int TAB_STEP    = 8;

   localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

   localparam logic [CSR_INDEX_W-1:0] CSR_FG = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG = 1'b1;

   localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

   localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] char_code;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] cell_value;
   } rsp_type;

endpackage

[sv/tcw_req_if.sv]
interface tcw_req_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::KIND_W-1:0]  kind;
   logic [tcw_pkg::CHAR_W-1:0]  char_code;
   logic [tcw_pkg::COL_W-1:0]   col;
   logic [tcw_pkg::ROW_W-1:0]   row;

   modport source (output valid, kind, char_code, col, row, input ready);
   modport sink (input valid, kind, char_code, col, row, output ready);
endinterface

[sv/tcw_rsp_if.sv]
interface tcw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::POS_W-1:0]   cursor_pos;
   logic [tcw_pkg::CELL_W-1:0]  cell_value;

   modport source (output valid, cursor_pos, cell_value, input ready);
   modport sink (input valid, cursor_pos, cell_value, output ready);
endinterface

[sv/tcw_cell_mem.sv]
module tcw_cell_mem #(
   parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [tcw_pkg::CELL_W-1:0]  rd_data
);

   logic [tcw_pkg::CELL_W-1:0] cells [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= cells[rd_addr];
   end

endmodule

[sv/tcw_engine.sv]
module tcw_engine #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS,
   parameter int AW      = $clog2(COLUMNS * ROWS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [2*tcw_pkg::COLOR_W-1:0] colour,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  tcw_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tcw_pkg::rsp_type             rsp_data,
   output logic                         mem_wr_en,
   output logic [AW-1:0]                mem_wr_addr,
   output logic [tcw_pkg::CELL_W-1:0]   mem_wr_data,
   output logic [AW-1:0]                mem_rd_addr,
   input  logic [tcw_pkg::CELL_W-1:0]   mem_rd_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int CXW   = CW + 1;
   localparam int RXW   = RW + 1;

   localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
   localparam logic [AW-1:0] BOTTOM_ROW  = AW'(CELLS - COLUMNS);

   localparam logic [2:0] ST_FILL   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCROLL = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;
   localparam logic [2:0] ST_RWAIT  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic          init_ff, init_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic [tcw_pkg::CELL_W-1:0]  blank;
   logic [CW-1:0]               col_cl;
   logic [RW-1:0]               row_cl;
   logic [CXW-1:0]              put_col;
   logic [RXW-1:0]              put_row;
   logic                        put_wr;
   logic                        put_scroll;
   logic [AW-1:0]               put_addr;
   logic [tcw_pkg::CELL_W-1:0]  put_data;
   logic [tcw_pkg::POS_W-1:0]   pos;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
      return AW'(32'(r) * COLUMNS + 32'(c));
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign blank     = {colour, tcw_pkg::CH_SPACE};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pos       = tcw_pkg::POS_W'(32'(row_ff) * COLUMNS + 32'(col_ff));

   assign col_cl = (32'(req_data.col) > 32'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(req_data.col);
   assign row_cl = (32'(req_data.row) > 32'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(req_data.row);

   // Cursor step of a put word, with at most one cell write.
   always_comb begin
      put_col    = {1'b0, col_ff};
      put_row    = {1'b0, row_ff};
      put_wr     = 1'b0;
      put_scroll = 1'b0;
      put_addr   = cell_addr(row_ff, col_ff);
      put_data   = {colour, req_data.char_code};
      if (req_data.char_code == tcw_pkg::CH_BACKSPACE) begin
         if (col_ff != '0) begin
            put_col = put_col - 1'b1;
            put_wr  = 1'b1;
         end else if (row_ff != '0) begin
            put_row = put_row - 1'b1;
            put_col = CXW'(COLUMNS - 1);
            put_wr  = 1'b1;
         end
         put_addr = cell_addr(put_row[RW-1:0], put_col[CW-1:0]);
         put_data = blank;
      end else begin
         if (req_data.char_code == tcw_pkg::CH_NEWLINE) begin
            put_col = '0;
            put_row = put_row + 1'b1;
         end else if (req_data.char_code == tcw_pkg::CH_RETURN) begin
            put_col = '0;
         end else if (req_data.char_code == tcw_pkg::CH_TAB) begin
            put_col = (put_col + CXW'(tcw_pkg::TAB_STEP)) & ~CXW'(tcw_pkg::TAB_STEP - 1);
         end else begin
            put_wr  = 1'b1;
            put_col = put_col + 1'b1;
         end
         if (32'(put_col) >= 32'(COLUMNS)) begin
            put_col = '0;
            put_row = put_row + 1'b1;
         end
         if (32'(put_row) >= 32'(ROWS)) begin
            put_row    = RXW'(ROWS - 1);
            put_scroll = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      init_in      = init_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = sweep_ff;
      mem_wr_data  = blank;
      mem_rd_addr  = cell_addr(row_cl, col_cl);
      unique case (state_ff)
         ST_FILL: begin
            mem_wr_en = 1'b1;
            if (init_ff) begin
               mem_wr_data = tcw_pkg::RESET_CELL;
            end
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               init_in  = 1'b0;
               state_in = init_ff ? ST_IDLE : ST_FINISH;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  tcw_pkg::KIND_PUT: begin
                     col_in      = put_col[CW-1:0];
                     row_in      = put_row[RW-1:0];
                     mem_wr_en   = put_wr;
                     mem_wr_addr = put_addr;
                     mem_wr_data = put_data;
                     sweep_in    = '0;
                     state_in    = put_scroll ? ST_SCROLL : ST_FINISH;
                  end
                  tcw_pkg::KIND_SET: begin
                     col_in   = col_cl;
                     row_in   = row_cl;
                     state_in = ST_FINISH;
                  end
                  tcw_pkg::KIND_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     sweep_in = '0;
                     state_in = ST_FILL;
                  end
                  tcw_pkg::KIND_READ: begin
                     state_in = ST_RWAIT;
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            // Reads run one row ahead; each read lands one row up in the next cycle.
            mem_rd_addr = sweep_ff + AW'(COLUMNS);
            if (sweep_ff != '0) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = sweep_ff - 1'b1;
               mem_wr_data = mem_rd_data;
            end
            if (sweep_ff == BOTTOM_ROW) begin
               state_in = ST_FILL;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{cursor_pos: pos, cell_value: '0};
            state_in     = ST_IDLE;
         end
         ST_RWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{cursor_pos: pos, cell_value: mem_rd_data};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         sweep_ff     <= '0;
         init_ff      <= 1'b1;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         init_ff      <= init_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[sv/text_console_writer.sv]
// Text-mode console writer with a COLUMNS x ROWS cell memory and a cursor.
// Request words on req_if carry a kind (put character, set cursor, clear
// screen, read cell), a character byte and a column and row. Every request
// word yields one response word on rsp_if with the linear cursor position
// and, for a read, the cell entry. The csr port writes the foreground and
// background colour nibbles; write it only while the block is idle.
// A put, set cursor or read passes through a finish state (a read-wait state
// for a read) before its response is registered, and no new word is taken
// until the block is back in idle. A put that moves below the last row
// scrolls the screen: a scroll state copies every row up through the cell
// memory, a fill state blanks the bottom row, and the finish state follows.
// A clear fills every cell in the fill state. After reset the cell memory
// is filled with grey blanks while req_if.ready stays low.
// A stalled response is held in the output register; a new request word is
// taken only once that register is empty or being emptied.
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   tcw_req_if.sink                          req_if,
   tcw_rsp_if.source                        rsp_if,
   input  logic                             csr_wr_en,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]      csr_wr_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   logic [tcw_pkg::COLOR_W-1:0] fg_ff, fg_in;
   logic [tcw_pkg::COLOR_W-1:0] bg_ff, bg_in;

   tcw_pkg::req_type            req_data;
   tcw_pkg::rsp_type            rsp_data;
   logic                        mem_wr_en;
   logic [AW-1:0]               mem_wr_addr;
   logic [tcw_pkg::CELL_W-1:0]  mem_wr_data;
   logic [AW-1:0]               mem_rd_addr;
   logic [tcw_pkg::CELL_W-1:0]  mem_rd_data;

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tcw_pkg::CSR_FG: fg_in = csr_wr_data;
            tcw_pkg::CSR_BG: bg_in = csr_wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= tcw_pkg::FG_RESET;
         bg_ff <= tcw_pkg::BG_RESET;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   assign req_data = '{kind: req_if.kind, char_code: req_if.char_code,
                       col: req_if.col, row: req_if.row};
   assign rsp_if.cursor_pos = rsp_data.cursor_pos;
   assign rsp_if.cell_value = rsp_data.cell_value;

   tcw_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .AW      (AW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .colour      ({bg_ff, fg_ff}),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   tcw_cell_mem #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_cell_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |-> (!rsp_if.valid || rsp_if.ready))
      else $error("request word taken while a response word is stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request channel ready right after an accepted word");

   a_pos_in_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ((CELLS > 2048) || (32'(rsp_if.cursor_pos) < CELLS)))
      else $error("cursor position outside the screen");

endmodule

[verif/tcw_console_check.sv]
module tcw_console_check
   import tcw_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   tcw_req_if                      req_if,
   tcw_rsp_if                      rsp_if,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [COLOR_W-1:0]      csr_wr_data,
   output int                      fail_count,
   output int                      pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCOLS = DEF_COLUMNS;
   localparam int NROWS = DEF_ROWS;
   localparam int NCELLS = NCOLS * NROWS;

   logic [CELL_W-1:0]  screen_mem [0:NCELLS-1];
   logic [COL_W-1:0]   cur_col;
   logic [ROW_W-1:0]   cur_row;
   logic [COLOR_W-1:0] fg_nib;
   logic [COLOR_W-1:0] bg_nib;
   rsp_type            console_q [$];
   int                 errors;

   // Applies one request word to the console image and returns the response
   // word that the block should give for it.
   function automatic rsp_type console_step(req_type w);
      logic [COL_W-1:0]  c;
      logic [ROW_W-1:0]  r;
      logic [CELL_W-1:0] blank;
      logic [CELL_W-1:0] read_val;
      rsp_type           res;
      c = (w.col > COL_W'(NCOLS - 1)) ? COL_W'(NCOLS - 1) : w.col;
      r = (w.row > ROW_W'(NROWS - 1)) ? ROW_W'(NROWS - 1) : w.row;
      blank = {bg_nib, fg_nib, CH_SPACE};
      read_val = '0;
      case (w.kind)
         KIND_PUT: begin
            if (w.char_code == CH_BACKSPACE) begin
               if (cur_col != '0) begin
                  cur_col--;
                  screen_mem[int'(cur_row) * NCOLS + int'(cur_col)] = blank;
               end else if (cur_row != '0) begin
                  cur_row--;
                  cur_col = COL_W'(NCOLS - 1);
                  screen_mem[int'(cur_row) * NCOLS + int'(cur_col)] = blank;
               end
            end else begin
               case (w.char_code)
                  CH_NEWLINE: begin
                     cur_col = '0;
                     cur_row++;
                  end
                  CH_RETURN: cur_col = '0;
                  CH_TAB: cur_col = COL_W'((int'(cur_col) + TAB_STEP) & ~(TAB_STEP - 1));
                  default: begin
                     screen_mem[int'(cur_row) * NCOLS + int'(cur_col)] =
                        {bg_nib, fg_nib, w.char_code};
                     cur_col++;
                  end
               endcase
               if (int'(cur_col) >= NCOLS) begin
                  cur_col = '0;
                  cur_row++;
               end
               if (int'(cur_row) >= NROWS) begin
                  for (int i = 0; i < NCOLS * (NROWS - 1); i++)
                     screen_mem[i] = screen_mem[i + NCOLS];
                  for (int i = NCOLS * (NROWS - 1); i < NCELLS; i++)
                     screen_mem[i] = blank;
                  cur_row = ROW_W'(NROWS - 1);
               end
            end
         end
         KIND_SET: begin
            cur_col = c;
            cur_row = r;
         end
         KIND_CLEAR: begin
            for (int i = 0; i < NCELLS; i++)
               screen_mem[i] = blank;
            cur_col = '0;
            cur_row = '0;
         end
         KIND_READ: read_val = screen_mem[int'(r) * NCOLS + int'(c)];
      endcase
      res.cursor_pos = POS_W'(int'(cur_row) * NCOLS + int'(cur_col));
      res.cell_value = read_val;
      return res;
   endfunction

   always @(posedge clock) begin
      req_type w;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NCELLS; i++)
            screen_mem[i] = RESET_CELL;
         cur_col = '0;
         cur_row = '0;
         fg_nib = FG_RESET;
         bg_nib = BG_RESET;
         console_q.delete();
         errors = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_FG)
               fg_nib = csr_wr_data;
            else if (csr_index == CSR_BG)
               bg_nib = csr_wr_data;
         end
         if (req_if.valid && req_if.ready) begin
            w.kind = req_if.kind;
            w.char_code = req_if.char_code;
            w.col = req_if.col;
            w.row = req_if.row;
            console_q.push_back(console_step(w));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (console_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, cursor_pos %0d cell_value %h", $time,
                        rsp_if.cursor_pos, rsp_if.cell_value);
            end else begin
               want = console_q.pop_front();
               if (rsp_if.cursor_pos !== want.cursor_pos
                   || rsp_if.cell_value !== want.cell_value) begin
                  errors++;
                  $display("%0t: expected cursor_pos %0d cell_value %h, got %0d %h",
                           $time, want.cursor_pos, want.cell_value,
                           rsp_if.cursor_pos, rsp_if.cell_value);
               end
            end
         end
      end
      pending_words <= console_q.size();
      fail_count <= errors;
   end

endmodule

[verif/tb_text_console_writer.sv]
module tb_text_console_writer;
   import tcw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = DEF_COLUMNS * DEF_ROWS + 100;
   localparam int WORDS_PER_SEGMENT = 255;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COLOR_W-1:0]     csr_wr_data;
   int                     fail_count;
   int                     pending_words;
   int                     send_idle_pct;
   int                     rsp_stall_pct;

   tcw_req_if req_if ();
   tcw_rsp_if rsp_if ();

   text_console_writer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   tcw_console_check console_check (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(200_000_000);
      $display("tb_text_console_writer: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                            input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind <= kind;
      req_if.char_code <= ch;
      req_if.col <= col;
      req_if.row <= row;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
   endtask

   // Waits until every word has come back and any scroll or clear has ended.
   task automatic drain_console();
      req_if.valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_words != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int                  pick;
      logic [KIND_W-1:0]   kind;
      logic [CHAR_W-1:0]   ch;
      logic [COLOR_W-1:0]  fg;
      logic [COLOR_W-1:0]  bg;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.kind = KIND_PUT;
      req_if.char_code = '0;
      req_if.col = '0;
      req_if.row = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_FG;
      csr_wr_data = '0;
      send_idle_pct = 12;
      rsp_stall_pct = 51;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_word(KIND_READ, 8'h00, 7'd0, 5'd0);
      send_word(KIND_READ, 8'hFF, 7'd127, 5'd31);
      send_word(KIND_PUT, CH_BACKSPACE, 7'd0, 5'd0);
      send_word(KIND_PUT, 8'h41, 7'd0, 5'd0);
      send_word(KIND_PUT, 8'h00, 7'd0, 5'd0);
      send_word(KIND_PUT, 8'hFF, 7'd0, 5'd0);
      send_word(KIND_PUT, CH_TAB, 7'd0, 5'd0);
      send_word(KIND_PUT, CH_BACKSPACE, 7'd0, 5'd0);
      send_word(KIND_PUT, CH_RETURN, 7'd0, 5'd0);
      send_word(KIND_PUT, CH_NEWLINE, 7'd0, 5'd0);
      send_word(KIND_PUT, CH_BACKSPACE, 7'd0, 5'd0);
      send_word(KIND_READ, 8'h00, 7'd79, 5'd0);
      send_word(KIND_SET, 8'h00, 7'd127, 5'd31);
      send_word(KIND_PUT, 8'h5A, 7'd0, 5'd0);
      send_word(KIND_READ, 8'h00, 7'd79, 5'd23);
      send_word(KIND_SET, 8'h00, 7'd76, 5'd3);
      send_word(KIND_PUT, CH_TAB, 7'd0, 5'd0);
      send_word(KIND_SET, 8'h00, 7'd72, 5'd24);
      send_word(KIND_PUT, CH_TAB, 7'd0, 5'd0);
      send_word(KIND_PUT, CH_NEWLINE, 7'd0, 5'd0);
      send_word(KIND_READ, 8'h00, 7'd0, 5'd0);
      send_word(KIND_CLEAR, 8'h00, 7'd0, 5'd0);
      send_word(KIND_READ, 8'h00, 7'd5, 5'd5);
      send_word(KIND_SET, 8'hFF, 7'd80, 5'd25);
      send_word(KIND_PUT, CH_SPACE, 7'd0, 5'd0);

      for (int seg = 0; seg < 6; seg++) begin
         drain_console();
         case (seg)
            0: begin fg = 4'd15; bg = 4'd15; end
            1: begin fg = 4'd0;  bg = 4'd0;  end
            2: begin fg = 4'd15; bg = 4'd0;  end
            3: begin fg = 4'd0;  bg = 4'd15; end
            default: begin
               fg = COLOR_W'($urandom_range(15));
               bg = COLOR_W'($urandom_range(15));
            end
         endcase
         csr_wr_en <= 1'b1;
         csr_index <= CSR_FG;
         csr_wr_data <= fg;
         @(posedge clock);
         csr_index <= CSR_BG;
         csr_wr_data <= bg;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         case (seg / 2)
            0: begin send_idle_pct = 12; rsp_stall_pct = 51; end
            1: begin send_idle_pct = 51; rsp_stall_pct = 12; end
            default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         endcase

         // Mostly runs of text with some control codes, cursor moves, reads and clears.
         for (int n = 0; n < WORDS_PER_SEGMENT; n++) begin
            pick = $urandom_range(99);
            ch = CHAR_W'($urandom_range(255));
            if (pick < 2)
               kind = KIND_CLEAR;
            else if (pick < 16)
               kind = KIND_SET;
            else if (pick < 30)
               kind = KIND_READ;
            else begin
               kind = KIND_PUT;
               pick = $urandom_range(99);
               if (pick < 6)
                  ch = CH_NEWLINE;
               else if (pick < 9)
                  ch = CH_RETURN;
               else if (pick < 14)
                  ch = CH_TAB;
               else if (pick < 20)
                  ch = CH_BACKSPACE;
            end
            send_word(kind, ch, COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)));
         end
      end

      drain_console();
      if (fail_count == 0 && pending_words == 0)
         $display("tb_text_console_writer: done, clean");
      else
         $display("tb_text_console_writer: done, errors");
      $finish;
   end

endmodule
